/* hw/rtl/s5hp_pkg.sv */
package s5hp_pkg;

	localparam int unsigned CountWidth = 9;
	localparam int unsigned ByteWidth  = 8;

	typedef enum logic [3:0] {
		PH_B0   = 4'd0,
		PH_B1   = 4'd1,
		PH_B2   = 4'd2,
		PH_ATYP = 4'd3,
		PH_ADDR = 4'd4,
		PH_DLEN = 4'd5,
		PH_DOM  = 4'd6,
		PH_P0   = 4'd7,
		PH_P1   = 4'd8
	} phase_t;

	localparam logic [1:0] ST_ADDR   = 2'd0;
	localparam logic [1:0] ST_ACCEPT = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TRUNC     = 3'd1;
	localparam logic [2:0] ERR_VERSION   = 3'd2;
	localparam logic [2:0] ERR_RESERVED  = 3'd3;
	localparam logic [2:0] ERR_ATYP      = 3'd4;
	localparam logic [2:0] ERR_EMPTY_DOM = 3'd5;
	localparam logic [2:0] ERR_ZERO_DOM  = 3'd6;
	localparam logic [2:0] ERR_TRAILING  = 3'd7;

	localparam logic [7:0] SOCKS_VERSION = 8'd5;
	localparam logic [7:0] ATYP_IPV4     = 8'd1;
	localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
	localparam logic [7:0] ATYP_IPV6     = 8'd4;
	localparam logic [8:0] IPV4_BYTES    = 9'd4;
	localparam logic [8:0] IPV6_BYTES    = 9'd16;
	localparam logic [7:0] FIXED_BYTES   = 8'd4;

	localparam logic MODE_REQUEST = 1'b0;
	localparam logic MODE_UDP     = 1'b1;

	typedef struct packed {
		phase_t                  phase;
		logic [CountWidth-1:0]   byte_count;
		logic [ByteWidth-1:0]    domain_left;
		logic [ByteWidth-1:0]    atyp;
		logic [ByteWidth-1:0]    cmd_or_frag;
		logic [ByteWidth-1:0]    port_high;
		logic                    finished;
	} parse_state_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [ByteWidth-1:0]  addr_byte;
		logic [ByteWidth-1:0]  addr_index;
		logic [ByteWidth-1:0]  command;
		logic [ByteWidth-1:0]  addr_type;
		logic [ByteWidth-1:0]  frag;
		logic [15:0]           dest_port;
		logic [CountWidth-1:0] hdr_length;
		logic [2:0]            fault_code;
	} result_t;

	localparam parse_state_t STATE_CLEAR = '{
		phase:       PH_B0,
		byte_count:  '0,
		domain_left: '0,
		atyp:        '0,
		cmd_or_frag: '0,
		port_high:   '0,
		finished:    1'b0
	};

endpackage

/* hw/rtl/s5hp_step.sv */
module s5hp_step (
	input  s5hp_pkg::parse_state_t cur,
	input  logic [7:0]             data_byte,
	input  logic                   last,
	input  logic                   mode,
	output s5hp_pkg::parse_state_t nxt,
	output logic                   res_valid,
	output s5hp_pkg::result_t      res
);

	logic [2:0]  err;
	logic        addr_out;
	logic        accept;
	logic [7:0]  aidx;
	logic [15:0] port;
	logic [8:0]  addr_size;

	always_comb begin
		nxt       = cur;
		err       = s5hp_pkg::ERR_NONE;
		addr_out  = 1'b0;
		accept    = 1'b0;
		aidx      = '0;
		port      = '0;
		addr_size = (cur.atyp == s5hp_pkg::ATYP_IPV4) ? s5hp_pkg::IPV4_BYTES
			: s5hp_pkg::IPV6_BYTES;
		res_valid = 1'b0;
		res       = '0;

		if (cur.finished) begin
			if (last) begin
				nxt = s5hp_pkg::STATE_CLEAR;
			end
		end else begin
			nxt.byte_count = cur.byte_count + 9'd1;
			case (cur.phase)
				s5hp_pkg::PH_B1: begin
					if (mode == s5hp_pkg::MODE_REQUEST) begin
						nxt.cmd_or_frag = data_byte;
					end else if (data_byte != 8'd0) begin
						err = s5hp_pkg::ERR_VERSION;
					end
					nxt.phase = s5hp_pkg::PH_B2;
				end
				s5hp_pkg::PH_B2: begin
					if (mode == s5hp_pkg::MODE_REQUEST) begin
						if (data_byte != 8'd0) begin
							err = s5hp_pkg::ERR_RESERVED;
						end
					end else begin
						nxt.cmd_or_frag = data_byte;
					end
					nxt.phase = s5hp_pkg::PH_ATYP;
				end
				s5hp_pkg::PH_ATYP: begin
					nxt.atyp = data_byte;
					if (data_byte inside {s5hp_pkg::ATYP_IPV4, s5hp_pkg::ATYP_IPV6}) begin
						nxt.phase = s5hp_pkg::PH_ADDR;
					end else if (data_byte == s5hp_pkg::ATYP_DOMAIN) begin
						nxt.phase = s5hp_pkg::PH_DLEN;
					end else begin
						err = s5hp_pkg::ERR_ATYP;
					end
				end
				s5hp_pkg::PH_ADDR: begin
					aidx     = cur.byte_count[7:0] - s5hp_pkg::FIXED_BYTES;
					addr_out = 1'b1;
					if ({1'b0, aidx} + 9'd1 >= addr_size) begin
						nxt.phase = s5hp_pkg::PH_P0;
					end
				end
				s5hp_pkg::PH_DLEN: begin
					if (data_byte == 8'd0) begin
						err = s5hp_pkg::ERR_EMPTY_DOM;
					end else begin
						nxt.domain_left = data_byte;
						nxt.phase       = s5hp_pkg::PH_DOM;
					end
				end
				s5hp_pkg::PH_DOM: begin
					if (data_byte == 8'd0) begin
						err = s5hp_pkg::ERR_ZERO_DOM;
					end else begin
						aidx            = cur.byte_count[7:0] - s5hp_pkg::FIXED_BYTES - 8'd1;
						addr_out        = 1'b1;
						nxt.domain_left = cur.domain_left - 8'd1;
						if (cur.domain_left == 8'd1) begin
							nxt.phase = s5hp_pkg::PH_P0;
						end
					end
				end
				s5hp_pkg::PH_P0: begin
					nxt.port_high = data_byte;
					nxt.phase     = s5hp_pkg::PH_P1;
				end
				s5hp_pkg::PH_P1: begin
					port = {cur.port_high, data_byte};
					if (mode == s5hp_pkg::MODE_REQUEST && !last) begin
						err = s5hp_pkg::ERR_TRAILING;
					end else begin
						accept = 1'b1;
					end
				end
				default: begin
					if (mode == s5hp_pkg::MODE_REQUEST) begin
						if (data_byte != s5hp_pkg::SOCKS_VERSION) begin
							err = s5hp_pkg::ERR_VERSION;
						end
					end else if (data_byte != 8'd0) begin
						err = s5hp_pkg::ERR_VERSION;
					end
					nxt.phase = s5hp_pkg::PH_B1;
				end
			endcase

			res.command   = (mode == s5hp_pkg::MODE_REQUEST) ? nxt.cmd_or_frag : 8'd0;
			res.frag      = (mode == s5hp_pkg::MODE_UDP) ? nxt.cmd_or_frag : 8'd0;
			res.addr_type = nxt.atyp;

			if (err != s5hp_pkg::ERR_NONE) begin
				res_valid      = 1'b1;
				res.status     = s5hp_pkg::ST_REJECT;
				res.fault_code = err;
				nxt.finished   = 1'b1;
			end else if (accept) begin
				res_valid      = 1'b1;
				res.status     = s5hp_pkg::ST_ACCEPT;
				res.dest_port  = port;
				res.hdr_length = nxt.byte_count;
				nxt.finished   = 1'b1;
			end else if (last) begin
				res_valid      = 1'b1;
				res.status     = s5hp_pkg::ST_REJECT;
				res.fault_code = s5hp_pkg::ERR_TRUNC;
			end else if (addr_out) begin
				res_valid      = 1'b1;
				res.status     = s5hp_pkg::ST_ADDR;
				res.addr_byte  = data_byte;
				res.addr_index = aidx;
			end

			if (last) begin
				nxt = s5hp_pkg::STATE_CLEAR;
			end
		end
	end

endmodule

/* hw/rtl/socks5_header_parser.sv */
// SOCKS5 request / UDP header parser.
// Input channel: one message byte per transaction (data_byte, last), with
// in_valid/in_stall. last marks the final byte of a message buffer.
// Output channel: out_valid/out_stall carrying one result per transaction:
// an address byte, a header accept (port, length) or a reject (error code).
// Bytes that cause no result (fixed fields, trailing payload) produce nothing.
// Configuration: cfg_valid/cfg_ready/cfg_data writes the mode bit
// (0 request, 1 UDP); cfg_ready is always high. Write only while idle.
// Each taken byte is held in the input register, decoded combinationally,
// and its result is registered into the output register as it advances.
// Throughput: one byte per cycle while out_stall does not hold the output.
// Reset: mode returns to request, the parser waits for the first header byte,
// and no transaction is pending on either side.
// out_stall holds the result register; the input stage then fills and
// in_stall rises in the same cycle, so no byte is lost.
module socks5_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  addr_byte,
	output logic [7:0]  addr_index,
	output logic [7:0]  command,
	output logic [7:0]  addr_type,
	output logic [7:0]  frag,
	output logic [15:0] dest_port,
	output logic [8:0]  hdr_length,
	output logic [2:0]  fault_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	logic                   mode_q;
	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic                   last_s1;
	s5hp_pkg::parse_state_t state_q;
	s5hp_pkg::parse_state_t state_nxt;
	logic                   res_valid;
	s5hp_pkg::result_t      res;
	s5hp_pkg::result_t      out_q;
	logic                   adv;
	logic                   in_take;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_take   = in_valid && !in_stall;

	s5hp_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.last      (last_s1),
		.mode      (mode_q),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= s5hp_pkg::MODE_REQUEST;
			valid_s1  <= 1'b0;
			state_q   <= s5hp_pkg::STATE_CLEAR;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				state_q <= state_nxt;
			end
			if (adv && res_valid) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			last_s1 <= last;
		end
		if (adv && res_valid) begin
			out_q <= res;
		end
	end

	assign status     = out_q.status;
	assign addr_byte  = out_q.addr_byte;
	assign addr_index = out_q.addr_index;
	assign command    = out_q.command;
	assign addr_type  = out_q.addr_type;
	assign frag       = out_q.frag;
	assign dest_port  = out_q.dest_port;
	assign hdr_length = out_q.hdr_length;
	assign fault_code = out_q.fault_code;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> state_q.phase == s5hp_pkg::PH_B0 &&
			state_q.byte_count == '0 && !state_q.finished)
		else $error("state not cleared after last byte");

	a_silent_when_finished: assert property (@(posedge clk) disable iff (!arst_n)
		adv && state_q.finished |-> !res_valid)
		else $error("result produced after message finished");

	a_reject_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == s5hp_pkg::ST_REJECT) ==
			(fault_code != s5hp_pkg::ERR_NONE))
		else $error("reject and error code disagree");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked item");

endmodule
